[rtl/isst_pkg.sv]
package isst_pkg;

    // sizing defaults
    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 9;
    localparam int COUNT_W      = 7;

    // request actions
    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_APPEND = 2'd3;

    // per-cell operations broadcast along the chain
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

[rtl/isst_cell.sv]
module isst_cell import isst_pkg::*; #(
    parameter int IW = 6
) (
    input  logic              i_clk,
    input  logic [IW-1:0]     i_idx,
    input  logic [IW-1:0]     i_slot,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_value,
    output logic [DATA_W-1:0] o_tap
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    // shift toward the tail on insert, toward the head on delete
    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (i_idx > i_slot) begin
                    n_value = i_left;
                end else if (i_idx == i_slot) begin
                    n_value = i_ctl.value;
                end
            end
            CELL_DELETE: begin
                if (i_idx >= i_slot) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // read tap, zero unless this cell is addressed
    assign o_value = r_value;
    assign o_tap   = (i_idx == i_slot) ? r_value : '0;

endmodule

[rtl/indexed_sequence_store.sv]
// channel   | valid   | stall   | payload
// ----------+---------+---------+---------------------------------------------
// request   | i_valid | o_stall | i_action, i_position, i_item_value
// result    | o_valid | i_stall | o_read_value, o_found, o_accepted, o_count
//
// One request per cycle unless a held result stalls: every cell of the
// chain shifts in the same cycle, so an insert or delete anywhere is one
// shift; the output register holds the result in the cycle after transfer.
// A new request is taken while the output register is empty or being
// drained; a stalled result stalls the request side.
// Synchronous active-low reset empties the sequence; cell contents are
// not cleared and only positions below the length are ever read.
module indexed_sequence_store import isst_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_action,
    input  logic signed [POS_W-1:0]  i_position,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic                     o_found,
    output logic                     o_accepted,
    output logic [COUNT_W-1:0]       o_count
);

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = CW + POS_W;

    logic              r_valid;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [DATA_W-1:0] r_read_value;
    logic              r_found;
    logic              r_accepted;

    logic              xfer;
    logic              full;
    logic              pos_nn;
    logic [CMPW-1:0]   pos_w;
    logic [CMPW-1:0]   cnt_w;
    logic              in_range;
    logic              ins_ok;
    logic [IW-1:0]     slot;
    t_cell_ctl         ctl;
    logic              acc;
    logic [DATA_W-1:0] rd_value;
    logic              rd_found;
    logic [DATA_W-1:0] rd_bus;

    logic [DATA_W-1:0] cell_value [CAPACITY];
    logic [DATA_W-1:0] cell_tap   [CAPACITY];

    // handshake
    assign o_stall = r_valid & i_stall;
    assign xfer    = i_valid & ~o_stall;

    // position checks against the current length
    assign full     = (r_count == CW'(CAPACITY));
    assign pos_nn   = ~i_position[POS_W-1];
    assign pos_w    = CMPW'(i_position[POS_W-2:0]);
    assign cnt_w    = CMPW'(r_count);
    assign in_range = pos_nn & (pos_w < cnt_w);
    assign ins_ok   = ~full & (~pos_nn | (pos_w <= cnt_w));

    // decode the request into one chain operation
    always_comb begin
        slot      = i_position[IW-1:0];
        ctl.op    = CELL_HOLD;
        ctl.value = i_item_value;
        acc       = 1'b0;
        n_count   = r_count;
        case (i_action)
            ACT_INSERT: begin
                if (!pos_nn) begin
                    slot = '0;
                end
                if (ins_ok) begin
                    ctl.op  = CELL_INSERT;
                    acc     = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_DELETE: begin
                if (in_range) begin
                    ctl.op  = CELL_DELETE;
                    acc     = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            ACT_APPEND: begin
                slot = r_count[IW-1:0];
                if (!full) begin
                    ctl.op  = CELL_INSERT;
                    acc     = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
                ctl.op = CELL_HOLD;
            end
        endcase
        if (!xfer) begin
            ctl.op = CELL_HOLD;
        end
    end

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
        if (g == 0) begin : g_head
            assign left = '0;
        end else begin : g_mid
            assign left = cell_value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right = '0;
        end else begin : g_body
            assign right = cell_value[g+1];
        end
        isst_cell #(.IW(IW)) u_cell (
            .i_clk   (i_clk),
            .i_idx   (IW'(g)),
            .i_slot  (slot),
            .i_ctl   (ctl),
            .i_left  (left),
            .i_right (right),
            .o_value (cell_value[g]),
            .o_tap   (cell_tap[g])
        );
    end

    // read: only the addressed cell drives its tap
    always_comb begin
        rd_bus = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_bus = rd_bus | cell_tap[k];
        end
    end

    always_comb begin
        rd_value = '0;
        rd_found = 1'b0;
        if (i_action == ACT_READ) begin
            if (in_range) begin
                rd_value = rd_bus;
                rd_found = 1'b1;
            end else begin
                rd_value = '1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (xfer) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_read_value <= rd_value;
            r_found      <= rd_found;
            r_accepted   <= acc;
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_found      = r_found;
    assign o_accepted   = r_accepted;
    assign o_count      = COUNT_W'(r_count);

endmodule

[rtl/isst_checker.sv]
module isst_checker import isst_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [DATA_W-1:0] o_read_value,
    input logic                     o_found,
    input logic                     o_accepted,
    input logic [COUNT_W-1:0]       o_count
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_value) && $stable(o_found)
            && $stable(o_accepted) && $stable(o_count))
        else $error("stalled result changed");

    // the request side only stalls behind a held result
    a_stall: assert property (@(posedge i_clk) o_stall |-> o_valid && i_stall)
        else $error("request stalled without a held result");

    // a read never changes the sequence
    a_rd_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> !o_accepted)
        else $error("read reported as accepted");

    // a hit needs a non-empty sequence
    a_rd_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_count != '0)
        else $error("read hit on empty sequence");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind indexed_sequence_store isst_checker u_isst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_read_value (o_read_value),
    .o_found      (o_found),
    .o_accepted   (o_accepted),
    .o_count      (o_count)
);
